@@ design/clipped_pixel_write_palette_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clipped pixel write palette unit
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_PIXEL_WRITE_PALETTE_UNIT_MACROS_SVH
`define CLIPPED_PIXEL_WRITE_PALETTE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define CPWP_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cpwp assertion failed");
// same-cycle implication
`define CPWP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpwp implication failed");
// next-cycle implication
`define CPWP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpwp next-cycle implication failed");
`else
`define CPWP_ASSERT(label, clk, rst, cond)
`define CPWP_ASSERT_IMP(label, clk, rst, ante, cons)
`define CPWP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/cpwp_pkg.sv @@
// ----------------------------------------------------------------------------
// cpwp_pkg
// Shared constants, types and the palette reset table for the pixel unit.
// ----------------------------------------------------------------------------
package cpwp_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_DIM       = 4096;
  localparam int RGB_FLAG_BIT  = 24;

  localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
  localparam int PAL_CW   = $clog2(PALETTE_DEPTH + 1);
  localparam int CRD_W    = $clog2(MAX_DIM);
  localparam int FW_W     = $clog2(MAX_DIM + 1);
  localparam int PROD_W   = CRD_W + FW_W;
  localparam int ADDR_W   = 24;
  localparam int SUM_W    = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;
  localparam int XY_W     = 18;  // 16-bit signed offset plus 12-bit origin
  localparam int ARGB_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PAL_RESET_COUNT = 16;

  localparam logic [ARGB_W-1:0] ARGB_OPAQUE = 32'hFF00_0000;
  localparam logic [ARGB_W-1:0] ARGB_WHITE  = 32'hFFFF_FFFF;

  localparam logic [ARGB_W-1:0] BASE_COLOURS [16] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };

  typedef enum logic [1:0] {
    CMD_PUT_PIXEL     = 2'd0,
    CMD_SET_PALETTE   = 2'd1,
    CMD_CONVERT_INDEX = 2'd2,
    CMD_NOP           = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_VIEW_LEFT    = 3'd2,
    REG_VIEW_TOP     = 3'd3,
    REG_VIEW_RIGHT   = 3'd4,
    REG_VIEW_BOTTOM  = 3'd5,
    REG_CLIP_ENABLE  = 3'd6,
    REG_INDEXED_MODE = 3'd7
  } reg_idx_t;

  // where the result colour comes from
  typedef enum logic [2:0] {
    SRC_ZERO  = 3'd0,
    SRC_RGB   = 3'd1,
    SRC_PAL   = 3'd2,
    SRC_WHITE = 3'd3,
    SRC_BLACK = 3'd4
  } src_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [11:0] view_left;
    logic [11:0] view_top;
    logic [11:0] view_right;
    logic [11:0] view_bottom;
    logic        clip_enable;
    logic        indexed_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:  13'd640,
    frame_height: 13'd480,
    view_left:    12'd0,
    view_top:     12'd0,
    view_right:   12'd639,
    view_bottom:  12'd479,
    clip_enable:  1'b1,
    indexed_mode: 1'b0
  };

  // payload carried from issue to the resolve stage
  typedef struct packed {
    logic              argb_wr;
    logic              idx_wr;
    logic              use_xy;
    src_t              src;
    logic [CRD_W-1:0]  px;
    logic [CRD_W-1:0]  py;
    logic [FW_W-1:0]   fw;
    logic [ADDR_W-1:0] lin;
    logic [23:0]       rgb;
    logic [7:0]        idx_val;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [ARGB_W-1:0] data;
  } pal_wr_t;

  function automatic logic [ARGB_W-1:0] pal_reset_value(input logic [PAL_AW-1:0] a);
    logic [ARGB_W-1:0] v;
    v = '0;
    if (32'(a) < 32'd16) begin
      v = BASE_COLOURS[a[3:0]];
    end
    return v;
  endfunction

endpackage

@@ design/cpwp_ram.sv @@
// ----------------------------------------------------------------------------
// cpwp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/cpwp_palette.sv @@
// ----------------------------------------------------------------------------
// cpwp_palette
// Palette store: RAM plus per-entry written bits and the entry count.
// ----------------------------------------------------------------------------
module cpwp_palette (
  input  logic                          clk,
  input  logic                          rst,
  input  cpwp_pkg::pal_wr_t             wr,
  input  logic                          rd_en,
  input  logic [cpwp_pkg::PAL_AW-1:0]   rd_addr,
  output logic [cpwp_pkg::ARGB_W-1:0]   rd_data,
  output logic [cpwp_pkg::PAL_CW-1:0]   count
);

  logic [cpwp_pkg::PALETTE_DEPTH-1:0] written;
  logic                               rd_written;
  logic [cpwp_pkg::PAL_AW-1:0]        rd_addr_q;
  logic [cpwp_pkg::ARGB_W-1:0]        ram_q;

  cpwp_ram #(
    .WIDTH(cpwp_pkg::ARGB_W),
    .DEPTH(cpwp_pkg::PALETTE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      count   <= cpwp_pkg::PAL_CW'(cpwp_pkg::PAL_RESET_COUNT);
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
      if (32'(wr.addr) >= 32'(count)) begin
        count <= cpwp_pkg::PAL_CW'(32'(wr.addr) + 32'd1);
      end
    end
  end

  // sample the written flag with the read so it lines up with ram_q
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written <= written[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  assign rd_data = rd_written ? ram_q : cpwp_pkg::pal_reset_value(rd_addr_q);

endmodule

@@ design/cpwp_issue.sv @@
// ----------------------------------------------------------------------------
// cpwp_issue
// Command decode, viewport offset, clip and bounds tests, colour class.
// ----------------------------------------------------------------------------
module cpwp_issue (
  input  cpwp_pkg::cfg_t                 cfg,
  input  logic [cpwp_pkg::PAL_CW-1:0]    count,
  input  logic                           take,
  input  logic [1:0]                     command,
  input  logic signed [15:0]             pos_x,
  input  logic signed [15:0]             pos_y,
  input  logic signed [31:0]             colour,
  input  logic [7:0]                     entry_index,
  input  logic [31:0]                    entry_argb,
  input  logic [23:0]                    linear_position,
  output cpwp_pkg::stage_t               st,
  output cpwp_pkg::pal_wr_t              wr,
  output logic                           rd_en,
  output logic [cpwp_pkg::PAL_AW-1:0]    rd_addr
);

  logic signed [cpwp_pkg::XY_W-1:0] px;
  logic signed [cpwp_pkg::XY_W-1:0] py;
  logic [cpwp_pkg::FW_W-1:0]        fw;
  logic [cpwp_pkg::FW_W-1:0]        fh;
  logic                             clip_out;
  logic                             frame_out;
  logic                             is_rgb;
  logic                             pal_hit;
  logic                             idx_ok;

  always_comb begin
    px = cpwp_pkg::XY_W'(pos_x) + cpwp_pkg::XY_W'(cfg.view_left);
    py = cpwp_pkg::XY_W'(pos_y) + cpwp_pkg::XY_W'(cfg.view_top);
    fw = (32'(cfg.frame_width) > 32'(cpwp_pkg::MAX_DIM)) ?
         cpwp_pkg::FW_W'(cpwp_pkg::MAX_DIM) : cpwp_pkg::FW_W'(cfg.frame_width);
    fh = (32'(cfg.frame_height) > 32'(cpwp_pkg::MAX_DIM)) ?
         cpwp_pkg::FW_W'(cpwp_pkg::MAX_DIM) : cpwp_pkg::FW_W'(cfg.frame_height);

    clip_out = cfg.clip_enable &&
               ((px < $signed(cpwp_pkg::XY_W'(cfg.view_left))) ||
                (px > $signed(cpwp_pkg::XY_W'(cfg.view_right))) ||
                (py < $signed(cpwp_pkg::XY_W'(cfg.view_top))) ||
                (py > $signed(cpwp_pkg::XY_W'(cfg.view_bottom))));
    frame_out = px[cpwp_pkg::XY_W-1] || py[cpwp_pkg::XY_W-1] ||
                (32'(px[cpwp_pkg::XY_W-2:0]) >= 32'(fw)) ||
                (32'(py[cpwp_pkg::XY_W-2:0]) >= 32'(fh));

    is_rgb  = colour[cpwp_pkg::RGB_FLAG_BIT];
    pal_hit = (colour[31:cpwp_pkg::PAL_AW] == '0) &&
              (32'(colour[cpwp_pkg::PAL_AW-1:0]) < 32'(count));
    idx_ok  = 32'(entry_index) < 32'(cpwp_pkg::PALETTE_DEPTH);

    st      = '0;
    st.src  = cpwp_pkg::SRC_ZERO;
    wr      = '0;
    rd_en   = 1'b0;
    rd_addr = '0;

    unique case (cpwp_pkg::cmd_t'(command))
      cpwp_pkg::CMD_PUT_PIXEL: begin
        if (!clip_out && !frame_out) begin
          st.argb_wr = 1'b1;
          st.use_xy  = 1'b1;
          st.px      = px[cpwp_pkg::CRD_W-1:0];
          st.py      = py[cpwp_pkg::CRD_W-1:0];
          st.fw      = fw;
          st.rgb     = colour[23:0];
          if (is_rgb) begin
            st.src = cpwp_pkg::SRC_RGB;
          end else if (pal_hit) begin
            st.src  = cpwp_pkg::SRC_PAL;
            rd_en   = take;
            rd_addr = colour[cpwp_pkg::PAL_AW-1:0];
          end else begin
            st.src = cpwp_pkg::SRC_WHITE;
          end
          if (cfg.indexed_mode && (colour[31:8] == '0)) begin
            st.idx_wr  = 1'b1;
            st.idx_val = colour[7:0];
          end
        end
      end
      cpwp_pkg::CMD_SET_PALETTE: begin
        wr.en   = take && idx_ok;
        wr.addr = entry_index[cpwp_pkg::PAL_AW-1:0];
        wr.data = entry_argb;
      end
      cpwp_pkg::CMD_CONVERT_INDEX: begin
        if (cfg.indexed_mode) begin
          st.argb_wr = 1'b1;
          st.lin     = linear_position;
          if (32'(entry_index) < 32'(count)) begin
            st.src  = cpwp_pkg::SRC_PAL;
            rd_en   = take;
            rd_addr = entry_index[cpwp_pkg::PAL_AW-1:0];
          end else begin
            st.src = cpwp_pkg::SRC_BLACK;
          end
        end
      end
      cpwp_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/clipped_pixel_write_palette_unit.sv @@
// ----------------------------------------------------------------------------
// clipped_pixel_write_palette_unit
// Viewport-clipped pixel write front end with a 256-entry ARGB palette.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  cfg     | cfg_write              | cfg_index, cfg_data
//  in      | in_valid / in_stall    | command, pos_x, pos_y, colour, entry_index,
//          |                        | entry_argb, linear_position
//  out     | out_valid / out_stall  | argb_write, index_write, frame_address,
//          |                        | argb_value, index_value
//
// One transaction per clock in steady state while out_stall stays low; each
// input transaction yields exactly one output transaction once it is taken.
// The depth is the palette RAM's registered read plus the output register.
// Reset clears control state only; palette entries never written read as the
// default colour table through per-entry written bits, so no clearing pass.
// in_stall rises only when the resolve stage is full and the output register
// is held by out_stall.
//
module clipped_pixel_write_palette_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [cpwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpwp_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic signed [15:0]                  pos_x,
  input  logic signed [15:0]                  pos_y,
  input  logic signed [31:0]                  colour,
  input  logic [7:0]                          entry_index,
  input  logic [31:0]                         entry_argb,
  input  logic [23:0]                         linear_position,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                argb_write,
  output logic                                index_write,
  output logic [23:0]                         frame_address,
  output logic [31:0]                         argb_value,
  output logic [7:0]                          index_value
);

`include "clipped_pixel_write_palette_unit_macros.svh"

  cpwp_pkg::cfg_t                   cfg;
  cpwp_pkg::stage_t                 a_stage;
  cpwp_pkg::stage_t                 b_stage;
  cpwp_pkg::pal_wr_t                pal_wr;
  logic                             b_valid;
  logic                             in_take;
  logic                             out_adv;
  logic                             b_load;
  logic                             rd_en;
  logic [cpwp_pkg::PAL_AW-1:0]      rd_addr;
  logic [cpwp_pkg::ARGB_W-1:0]      pal_data;
  logic [cpwp_pkg::PAL_CW-1:0]      pal_count;
  logic [cpwp_pkg::PROD_W-1:0]      prod;
  logic [cpwp_pkg::SUM_W-1:0]       addr_sum;
  logic [23:0]                      addr_next;
  logic [31:0]                      argb_next;

  // --- configuration registers (to be written only while idle; not enforced) -
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= cpwp_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cpwp_pkg::reg_idx_t'(cfg_index))
        cpwp_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        cpwp_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        cpwp_pkg::REG_VIEW_LEFT:    cfg.view_left    <= cfg_data[11:0];
        cpwp_pkg::REG_VIEW_TOP:     cfg.view_top     <= cfg_data[11:0];
        cpwp_pkg::REG_VIEW_RIGHT:   cfg.view_right   <= cfg_data[11:0];
        cpwp_pkg::REG_VIEW_BOTTOM:  cfg.view_bottom  <= cfg_data[11:0];
        cpwp_pkg::REG_CLIP_ENABLE:  cfg.clip_enable  <= cfg_data[0];
        cpwp_pkg::REG_INDEXED_MODE: cfg.indexed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // --- flow control ----------------------------------------------------------
  // Output register drains when empty or not stalled; the resolve stage can
  // load whenever it is empty or moves into the output register.
  assign out_adv  = !out_valid || !out_stall;
  assign b_load   = !b_valid || out_adv;
  assign in_stall = !b_load;
  assign in_take  = in_valid && b_load;

  // --- issue: decode, clip, palette read or write ----------------------------
  // set_palette writes the RAM at issue. Reads also happen at issue, one
  // transaction per cycle, so a read always sees every earlier write and
  // never collides with a later one; the read data register holds while the
  // resolve stage is stalled.
  cpwp_issue u_issue (
    .cfg            (cfg),
    .count          (pal_count),
    .take           (in_take),
    .command        (command),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .colour         (colour),
    .entry_index    (entry_index),
    .entry_argb     (entry_argb),
    .linear_position(linear_position),
    .st             (a_stage),
    .wr             (pal_wr),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  cpwp_palette u_palette (
    .clk    (clk),
    .rst    (rst),
    .wr     (pal_wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(pal_data),
    .count  (pal_count)
  );

  // --- resolve stage ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b_stage <= a_stage;
    end
  end

  // row * width + column, kept to 24 bits
  always_comb begin
    prod      = cpwp_pkg::PROD_W'(b_stage.py) * cpwp_pkg::PROD_W'(b_stage.fw);
    addr_sum  = cpwp_pkg::SUM_W'(prod) + cpwp_pkg::SUM_W'(b_stage.px);
    addr_next = b_stage.use_xy ? addr_sum[23:0] : b_stage.lin;

    case (b_stage.src)
      cpwp_pkg::SRC_RGB:   argb_next = cpwp_pkg::ARGB_OPAQUE | 32'(b_stage.rgb);
      cpwp_pkg::SRC_PAL:   argb_next = pal_data;
      cpwp_pkg::SRC_WHITE: argb_next = cpwp_pkg::ARGB_WHITE;
      cpwp_pkg::SRC_BLACK: argb_next = cpwp_pkg::ARGB_OPAQUE;
      default:             argb_next = '0;
    endcase
  end

  // --- output register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && b_valid) begin
      argb_write    <= b_stage.argb_wr;
      index_write   <= b_stage.idx_wr;
      frame_address <= addr_next;
      argb_value    <= argb_next;
      index_value   <= b_stage.idx_val;
    end
  end

  // --- checks ----------------------------------------------------------------
  `CPWP_ASSERT_IMP(a_idx_needs_argb, clk, rst, out_valid && index_write, argb_write)
  `CPWP_ASSERT_IMP(a_no_write_is_zero, clk, rst, out_valid && !argb_write, (argb_value == '0) && (frame_address == '0) && (index_value == '0) && !index_write)
  `CPWP_ASSERT(a_count_range, clk, rst, (32'(pal_count) >= 32'd16) && (32'(pal_count) <= 32'(cpwp_pkg::PALETTE_DEPTH)))
  `CPWP_ASSERT_NXT(a_take_fills_stage, clk, rst, in_valid && !in_stall && !b_valid, b_valid)

endmodule

@@ tb/sv/clipped_pixel_write_palette_unit_test.sv @@
// ----------------------------------------------------------------------------
// clipped_pixel_write_palette_unit_test
// Self-checking bench for the clipped pixel write unit. Each command taken on
// the input channel is run through a local model of the viewport clip, frame
// bounds, colour resolution and palette. The model's frame write is queued,
// and each output transaction is compared against the oldest queued write.
// ----------------------------------------------------------------------------
module clipped_pixel_write_palette_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpwp_pkg::*;

  // one input command as it is offered on the input channel
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] colour;
    logic [7:0]  entry_index;
    logic [31:0] entry_argb;
    logic [23:0] linear_position;
  } pixel_cmd_t;

  // one frame write as it appears on the output channel
  typedef struct packed {
    logic        argb_write;
    logic        index_write;
    logic [23:0] frame_address;
    logic [31:0] argb_value;
    logic [7:0]  index_value;
  } frame_write_t;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [31:0] OPAQUE_WHITE = 32'hFFFF_FFFF;
  localparam int          DIM_LIMIT    = 4096;

  // palette contents out of reset: the 16 classic text-mode colours
  localparam logic [31:0] CGA_COLOURS [16] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };

  // --------------------------------------------------------------------------
  // clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  command         = '0;
  logic [15:0] pos_x           = '0;
  logic [15:0] pos_y           = '0;
  logic [31:0] colour          = '0;
  logic [7:0]  entry_index     = '0;
  logic [31:0] entry_argb      = '0;
  logic [23:0] linear_position = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        argb_write;
  logic        index_write;
  logic [23:0] frame_address;
  logic [31:0] argb_value;
  logic [7:0]  index_value;

  always #4 clk = ~clk;

  clipped_pixel_write_palette_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .colour          (colour),
    .entry_index     (entry_index),
    .entry_argb      (entry_argb),
    .linear_position (linear_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .argb_write      (argb_write),
    .index_write     (index_write),
    .frame_address   (frame_address),
    .argb_value      (argb_value),
    .index_value     (index_value)
  );

  // --------------------------------------------------------------------------
  // local copy of the block's registers and palette
  // --------------------------------------------------------------------------
  logic [12:0] cfg_fw      = 13'd640;
  logic [12:0] cfg_fh      = 13'd480;
  logic [11:0] cfg_left    = 12'd0;
  logic [11:0] cfg_top     = 12'd0;
  logic [11:0] cfg_right   = 12'd639;
  logic [11:0] cfg_bottom  = 12'd479;
  logic        cfg_clip    = 1'b1;
  logic        cfg_indexed = 1'b0;

  logic [31:0] palette_model [256];
  int          pal_entries = 16;

  pixel_cmd_t   pending_items [$];   // commands not yet offered
  frame_write_t expected_writes [$]; // predicted writes, oldest first
  int           fail_count = 0;
  int           accepted_items = 0;  // input transactions taken so far

  // sender state
  pixel_cmd_t offered;
  int         burst_left = 0;
  int         gap_left = 0;

  // receiver state
  int hold_left = 0;
  int next_hold_at = 300;
  int seg_left = 0;
  int stall_mode = 0;

  // palette lookup for put_pixel; RGB flag wins over everything else
  function automatic logic [31:0] resolve_colour(logic [31:0] c);
    int ci;
    ci = $signed(c);
    if (c[RGB_FLAG_BIT]) return OPAQUE_BLACK | {8'h00, c[23:0]};
    if (ci >= 0 && ci < pal_entries) return palette_model[c[7:0]];
    return OPAQUE_WHITE;
  endfunction

  // Works out the frame write caused by one command and updates the palette
  // copy for set_palette. Called in acceptance order only.
  function automatic frame_write_t predict_frame_write(pixel_cmd_t it);
    frame_write_t w;
    int px, py, fw, fh, vl, vt, vr, vb, ci;
    w  = '0;
    vl = cfg_left;
    vt = cfg_top;
    vr = cfg_right;
    vb = cfg_bottom;
    fw = (cfg_fw > DIM_LIMIT) ? DIM_LIMIT : cfg_fw;
    fh = (cfg_fh > DIM_LIMIT) ? DIM_LIMIT : cfg_fh;
    case (it.cmd)
      CMD_PUT_PIXEL: begin
        px = $signed(it.pos_x);
        py = $signed(it.pos_y);
        px = px + vl;
        py = py + vt;
        ci = $signed(it.colour);
        // viewport clip, then frame bounds (zero size frames drop everything)
        if (!(cfg_clip && (px < vl || px > vr || py < vt || py > vb)) &&
            px >= 0 && px < fw && py >= 0 && py < fh) begin
          w.argb_write    = 1'b1;
          w.frame_address = 24'(py * fw + px);
          w.argb_value    = resolve_colour(it.colour);
          if (cfg_indexed && ci >= 0 && ci < 256) begin
            w.index_write = 1'b1;
            w.index_value = it.colour[7:0];
          end
        end
      end
      CMD_SET_PALETTE: begin
        palette_model[it.entry_index] = it.entry_argb;
        if (int'(it.entry_index) >= pal_entries) pal_entries = int'(it.entry_index) + 1;
      end
      CMD_CONVERT_INDEX: begin
        if (cfg_indexed) begin
          w.argb_write    = 1'b1;
          w.frame_address = it.linear_position;
          w.argb_value    = (int'(it.entry_index) < pal_entries) ?
                            palette_model[it.entry_index] : OPAQUE_BLACK;
        end
      end
      default: ;  // unused code: no effect, all-zero result
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // every field random; unused fields of directed commands stay noisy
  function automatic pixel_cmd_t noise_cmd();
    pixel_cmd_t it;
    it.cmd             = cmd_t'($urandom_range(0, 3));
    it.pos_x           = 16'($urandom());
    it.pos_y           = 16'($urandom());
    it.colour          = $urandom();
    it.entry_index     = 8'($urandom());
    it.entry_argb      = $urandom();
    it.linear_position = 24'($urandom());
    return it;
  endfunction

  function automatic pixel_cmd_t put_cmd(logic [15:0] x, logic [15:0] y, logic [31:0] c);
    pixel_cmd_t it;
    it        = noise_cmd();
    it.cmd    = CMD_PUT_PIXEL;
    it.pos_x  = x;
    it.pos_y  = y;
    it.colour = c;
    return it;
  endfunction

  function automatic pixel_cmd_t pal_cmd(logic [7:0] i, logic [31:0] v);
    pixel_cmd_t it;
    it             = noise_cmd();
    it.cmd         = CMD_SET_PALETTE;
    it.entry_index = i;
    it.entry_argb  = v;
    return it;
  endfunction

  function automatic pixel_cmd_t conv_cmd(logic [7:0] i, logic [23:0] lin);
    pixel_cmd_t it;
    it                 = noise_cmd();
    it.cmd             = CMD_CONVERT_INDEX;
    it.entry_index     = i;
    it.linear_position = lin;
    return it;
  endfunction

  // Coordinate aimed mostly at the viewport and frame borders, returned
  // relative to the origin; a share is fully random or a 16-bit extreme.
  function automatic logic [15:0] pick_coord(int lim_a, int lim_b, int dim, int origin);
    int lo, hi, a;
    lo = (lim_a < lim_b) ? lim_a : lim_b;
    hi = (lim_a < lim_b) ? lim_b : lim_a;
    a  = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: a = lo - 2 + int'($urandom_range(0, hi - lo + 4));
      6, 7:             a = -2 + int'($urandom_range(0, dim + 3));
      8:                return 16'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
    endcase
    return 16'(a - origin);
  endfunction

  function automatic logic [31:0] pick_colour();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 7))
      0, 1: c = $urandom_range(0, 20);
      2:    c = $urandom_range(0, 300);
      3:    c[RGB_FLAG_BIT] = 1'b1;
      4:    c = 32'd0 - $urandom_range(1, 300);
      5: begin
        case ($urandom_range(0, 5))
          0:       c = 32'h8000_0000;
          1:       c = 32'h7FFF_FFFF;
          2:       c = 32'h00FF_FFFF;
          3:       c = 32'h0100_0000;
          4:       c = 32'd255;
          default: c = 32'd256;
        endcase
      end
      default: ;  // fully random word
    endcase
    return c;
  endfunction

  // random command mix for one phase, aimed at the current register setting
  function automatic pixel_cmd_t make_traffic_item();
    pixel_cmd_t it;
    int r, fw, fh;
    it = noise_cmd();
    r  = $urandom_range(0, 99);
    fw = (cfg_fw > DIM_LIMIT) ? DIM_LIMIT : cfg_fw;
    fh = (cfg_fh > DIM_LIMIT) ? DIM_LIMIT : cfg_fh;
    if (r < 60) begin
      it.cmd    = CMD_PUT_PIXEL;
      it.pos_x  = pick_coord(cfg_left, cfg_right, fw, cfg_left);
      it.pos_y  = pick_coord(cfg_top, cfg_bottom, fh, cfg_top);
      it.colour = pick_colour();
    end else if (r < 75) begin
      it.cmd = CMD_SET_PALETTE;
      if ($urandom_range(0, 1) == 0) it.entry_index = 8'($urandom_range(0, 20));
    end else if (r < 95) begin
      it.cmd = CMD_CONVERT_INDEX;
      if ($urandom_range(0, 1) == 0) it.entry_index = 8'($urandom_range(0, 20));
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  // drive one register write; cfg_write stays high for back-to-back writes
  task automatic write_reg(reg_idx_t ri, logic [12:0] d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= d;
    case (ri)
      REG_FRAME_WIDTH:  cfg_fw      = d;
      REG_FRAME_HEIGHT: cfg_fh      = d;
      REG_VIEW_LEFT:    cfg_left    = d[11:0];
      REG_VIEW_TOP:     cfg_top     = d[11:0];
      REG_VIEW_RIGHT:   cfg_right   = d[11:0];
      REG_VIEW_BOTTOM:  cfg_bottom  = d[11:0];
      REG_CLIP_ENABLE:  cfg_clip    = d[0];
      REG_INDEXED_MODE: cfg_indexed = d[0];
      default: ;
    endcase
  endtask

  task automatic apply_frame_config(logic [12:0] fw, logic [12:0] fh,
                                    logic [12:0] vl, logic [12:0] vt,
                                    logic [12:0] vr, logic [12:0] vb,
                                    logic [12:0] clip, logic [12:0] indexed);
    write_reg(REG_FRAME_WIDTH,  fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_VIEW_LEFT,    vl);
    write_reg(REG_VIEW_TOP,     vt);
    write_reg(REG_VIEW_RIGHT,   vr);
    write_reg(REG_VIEW_BOTTOM,  vb);
    write_reg(REG_CLIP_ENABLE,  clip);
    write_reg(REG_INDEXED_MODE, indexed);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // every command offered and taken, every predicted write seen
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_writes.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps; a stalled
  // transaction is held unchanged until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_writes.push_back(predict_frame_write(offered));
        accepted_items <= accepted_items + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          offered         = pending_items.pop_front();
          in_valid        <= 1'b1;
          command         <= offered.cmd;
          pos_x           <= offered.pos_x;
          pos_y           <= offered.pos_y;
          colour          <= offered.colour;
          entry_index     <= offered.entry_index;
          entry_argb      <= offered.entry_argb;
          linear_position <= offered.linear_position;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern changes after each random-length segment (never,
  // light, alternating, heavy). From 300 taken commands on, every 400 more,
  // it holds off while plenty are queued, so the pipe fills and in_stall rises.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && accepted_items >= next_hold_at && pending_items.size() > 40) begin
        hold_left    = 64;
        next_hold_at = next_hold_at + 400;
      end
      if (seg_left == 0) begin
        seg_left   = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each output transaction against the oldest predicted write
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    frame_write_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        $error("output transaction with no command pending");
        fail_count++;
      end else begin
        w = expected_writes.pop_front();
        if (argb_write !== w.argb_write) begin
          $error("argb_write: expected %0d, actual %0d", w.argb_write, argb_write);
          fail_count++;
        end
        if (index_write !== w.index_write) begin
          $error("index_write: expected %0d, actual %0d", w.index_write, index_write);
          fail_count++;
        end
        if (frame_address !== w.frame_address) begin
          $error("frame_address: expected %h, actual %h", w.frame_address, frame_address);
          fail_count++;
        end
        if (argb_value !== w.argb_value) begin
          $error("argb_value: expected %h, actual %h", w.argb_value, argb_value);
          fail_count++;
        end
        if (index_value !== w.index_value) begin
          $error("index_value: expected %h, actual %h", w.index_value, index_value);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    pixel_cmd_t it;
    int n;
    for (int i = 0; i < 256; i++) palette_model[i] = (i < 16) ? CGA_COLOURS[i] : 32'h0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset setting: 640x480 frame, full viewport, clip on
    pending_items.push_back(put_cmd(16'd0, 16'd0, 32'd0));         // first pixel
    pending_items.push_back(put_cmd(16'd639, 16'd479, 32'd15));    // last pixel
    pending_items.push_back(put_cmd(16'd640, 16'd0, 32'd1));       // right of viewport
    pending_items.push_back(put_cmd(16'd0, 16'd480, 32'd1));       // below viewport
    pending_items.push_back(put_cmd(16'hFFFF, 16'd0, 32'd1));      // x = -1
    pending_items.push_back(put_cmd(16'h8000, 16'h7FFF, 32'd1));
    pending_items.push_back(put_cmd(16'h7FFF, 16'h8000, 32'd1));
    pending_items.push_back(put_cmd(16'd5, 16'd5, 32'h0112_3456)); // RGB flagged
    pending_items.push_back(put_cmd(16'd5, 16'd6, 32'hFFFF_FFFF)); // negative, flag set
    pending_items.push_back(put_cmd(16'd6, 16'd5, 32'h8000_0000)); // negative, no flag
    pending_items.push_back(put_cmd(16'd7, 16'd7, 32'd16));        // just past palette
    pending_items.push_back(conv_cmd(8'd5, 24'h00_1234));          // not indexed: zeros
    it     = noise_cmd();
    it.cmd = CMD_NOP;
    pending_items.push_back(it);
    wait_idle();

    // directed, indexed mode: origin (100,50), clip off, width saturates at 4096
    apply_frame_config(13'd8191, 13'd4096, 13'd100, 13'd50, 13'd0, 13'd0, 13'd0, 13'd1);
    pending_items.push_back(conv_cmd(8'd16, 24'h00_0000));          // past palette: black
    pending_items.push_back(conv_cmd(8'd15, 24'hFF_FFFF));
    pending_items.push_back(put_cmd(16'hFF9C, 16'hFFCE, 32'd0));    // (-100,-50) -> (0,0)
    pending_items.push_back(put_cmd(16'd3995, 16'd4045, 32'd255)); // frame corner
    pending_items.push_back(put_cmd(16'd3996, 16'd0, 32'd1));      // column 4096
    pending_items.push_back(put_cmd(16'd0, 16'd0, 32'd256));       // no index byte
    pending_items.push_back(put_cmd(16'hFF9B, 16'd0, 32'd1));      // column -1
    pending_items.push_back(pal_cmd(8'd200, 32'h1234_5678));       // grows palette
    pending_items.push_back(put_cmd(16'd1, 16'd1, 32'd200));
    pending_items.push_back(put_cmd(16'd1, 16'd2, 32'd201));
    pending_items.push_back(conv_cmd(8'd201, 24'h00_00FF));
    pending_items.push_back(pal_cmd(8'd255, 32'hDEAD_BEEF));
    pending_items.push_back(conv_cmd(8'd255, 24'h80_0000));
    pending_items.push_back(pal_cmd(8'd3, 32'h0000_0000));         // no growth
    pending_items.push_back(put_cmd(16'd2, 16'd2, 32'd3));
    wait_idle();

    // random phases; the first few pin register extremes
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: apply_frame_config(13'd4096, 13'd4096, 13'd0, 13'd0, 13'd4095, 13'd4095,
                              13'd1, 13'd1);
        1: apply_frame_config(13'd1, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0, 13'd1, 13'd0);
        2: apply_frame_config(13'd0, 13'd200, 13'd0, 13'd0, 13'd639, 13'd479,
                              13'd0, 13'd1);
        3: apply_frame_config(13'd8191, 13'd8191, 13'd4095, 13'd4095, 13'd4095, 13'd4095,
                              13'd1, 13'd1);
        4: apply_frame_config(13'd300, 13'd0, 13'd10, 13'd10, 13'd200, 13'd200,
                              13'd0, 13'd0);
        default: begin
          int fw, fh, vl, vt, vr, vb;
          case ($urandom_range(0, 3))
            0:       fw = $urandom_range(1, 64);
            1:       fw = $urandom_range(1, 4096);
            2:       fw = $urandom_range(0, 8191);
            default: fw = 640;
          endcase
          case ($urandom_range(0, 3))
            0:       fh = $urandom_range(1, 64);
            1:       fh = $urandom_range(1, 4096);
            2:       fh = $urandom_range(0, 8191);
            default: fh = 480;
          endcase
          vl = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 4095);
          vt = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 4095);
          // right/bottom mostly past left/top; sometimes an empty viewport
          vr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : vl + $urandom_range(0, 100);
          vb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : vt + $urandom_range(0, 100);
          if (vr > 4095) vr = 4095;
          if (vb > 4095) vb = 4095;
          // bit 12 of the 12-bit registers and upper bits of the flags are noise
          apply_frame_config(13'(fw), 13'(fh),
                             {1'($urandom()), 12'(vl)}, {1'($urandom()), 12'(vt)},
                             {1'($urandom()), 12'(vr)}, {1'($urandom()), 12'(vb)},
                             13'($urandom()), 13'($urandom()));
        end
      endcase
      n = 0;
      while (n < 100) begin
        it = make_traffic_item();
        pending_items.push_back(it);
        if (it.cmd != CMD_NOP) n++;
      end
      wait_idle();
    end

    // drain: keep running so a stray extra result would be caught
    repeat (8) @(posedge clk);
    if (expected_writes.size() != 0) begin
      $error("%0d predicted writes never arrived", expected_writes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("clipped_pixel_write_palette_unit_test OK");
    end else begin
      $display("clipped_pixel_write_palette_unit_test NOT OK");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("clipped_pixel_write_palette_unit_test NOT OK");
    $finish;
  end

endmodule
